// ===== rtl/double_ended_queue_core_assert.svh =====
// ----------------------------------------------------------------------------
// Deque assertion macros
// Shared concurrent-assertion forms used by the deque RTL.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define DQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset.
`define DQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/dq_pkg.sv =====
// ----------------------------------------------------------------------------
// Deque package
// Operation and status codes, controller states and port word types.
// ----------------------------------------------------------------------------
`default_nettype none

package dq_pkg;

    localparam int MODE_W      = 3;
    localparam int VALUE_W     = 32;
    localparam int POS_W       = 10;
    localparam int DATA_OUT_W  = 32;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 11;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_BACK  = 3'd0,
        MODE_PUSH_FRONT = 3'd1,
        MODE_POP_BACK   = 3'd2,
        MODE_POP_FRONT  = 3'd3,
        MODE_READ_AT    = 3'd4
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_POP_EMPTY = 2'd1,
        STAT_PUSH_FULL = 2'd2,
        STAT_BAD_POS   = 2'd3
    } t_status;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RESP = 1'b1
    } t_state;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [VALUE_W-1:0] push_value;
        logic [POS_W-1:0]   position;
    } t_dq_in;

    typedef struct packed {
        logic [DATA_OUT_W-1:0]  data_out;
        logic [STATUS_W-1:0]    status;
        logic [COUNT_OUT_W-1:0] count_after;
        logic                   is_empty;
    } t_dq_out;

    // Decoded operation from the pointer unit to the top-level sequencer.
    typedef struct packed {
        t_status status;
        logic    take_data;
        logic    mem_wr;
        logic    mem_rd;
    } t_dq_plan;

endpackage

`default_nettype wire

// ===== rtl/double_ended_queue_core.sv =====
// Double-ended queue of DEPTH words in a single-port ring memory. Each input
// word is one operation (push back, push front, pop back, pop front, read at
// a position from the front) and yields exactly one output word with the
// data, a status, the count after the operation and an empty flag. An
// operation's accept cycle updates the slot pointers and performs the single
// memory access; in the response state the result, with the registered read
// data of the ring memory, is loaded into the output register. A stalled
// output holds the next result back until taken. The memory is not cleared
// after reset; only entries written by pushes are read.
// ----------------------------------------------------------------------------
// Deque core top level
// Sequencer, output register, pointer unit and ring memory.
// ----------------------------------------------------------------------------
`default_nettype none

`include "double_ended_queue_core_assert.svh"

module double_ended_queue_core #(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire dq_pkg::t_dq_in  i_in_word,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output dq_pkg::t_dq_out      o_out_word
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    dq_pkg::t_state   r_state, n_state;
    dq_pkg::t_dq_plan plan, r_plan;
    logic [AW-1:0]    mem_addr;
    logic [CW-1:0]    count_after;
    logic [DATA_WIDTH-1:0] ram_rdata;

    logic [dq_pkg::COUNT_OUT_W-1:0] r_count_out;
    logic                           r_empty;
    logic                           r_out_valid;
    dq_pkg::t_dq_out                r_out_word;

    logic in_fire, load_out;

    assign o_in_ready = (r_state == dq_pkg::ST_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;

    dq_ptr #(
        .DEPTH(DEPTH)
    ) u_ptr (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (in_fire),
        .i_word        (i_in_word),
        .o_plan        (plan),
        .o_addr        (mem_addr),
        .o_count_after (count_after)
    );

    dq_ring_ram #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_wr_en (in_fire && plan.mem_wr),
        .i_rd_en (in_fire && plan.mem_rd),
        .i_addr  (mem_addr),
        .i_wdata (DATA_WIDTH'(i_in_word.push_value)),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        load_out = 1'b0;
        unique case (r_state)
            dq_pkg::ST_IDLE: begin
                if (in_fire) begin
                    n_state = dq_pkg::ST_RESP;
                end
            end
            dq_pkg::ST_RESP: begin
                if (!r_out_valid || i_out_ready) begin
                    load_out = 1'b1;
                    n_state  = dq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dq_pkg::ST_IDLE;
            end
        endcase
    end

    // per-word result info captured at accept; read data comes registered from the ring memory
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_plan      <= plan;
            r_count_out <= dq_pkg::COUNT_OUT_W'(count_after);
            r_empty     <= (count_after == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_word.data_out    <= r_plan.take_data
                                      ? dq_pkg::DATA_OUT_W'(ram_rdata) : '0;
            r_out_word.status      <= r_plan.status;
            r_out_word.count_after <= r_count_out;
            r_out_word.is_empty    <= r_empty;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    `DQ_ASSERT_NXT(a_one_in_flight, i_clk, i_rst_n, in_fire, !o_in_ready, "new word accepted while one is in flight")
    `DQ_ASSERT_IMP(a_result_from_resp, i_clk, i_rst_n, $rose(o_out_valid), $past(r_state == dq_pkg::ST_RESP), "result appeared without a pending operation")
    `DQ_ASSERT_NXT(a_resp_waits, i_clk, i_rst_n, (r_state == dq_pkg::ST_RESP) && r_out_valid && !i_out_ready, r_state == dq_pkg::ST_RESP, "pending result dropped under output stall")

endmodule

`default_nettype wire

// ===== rtl/dq_ring_ram.sv =====
// ----------------------------------------------------------------------------
// Deque ring memory
// Single-port synchronous RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_ring_ram #(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [DATA_WIDTH-1:0]    i_wdata,
    output logic      [DATA_WIDTH-1:0]    o_rdata
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_addr] <= i_wdata;
        end
        if (i_rd_en) begin
            r_rdata <= mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/dq_ptr.sv =====
// ----------------------------------------------------------------------------
// Deque pointer unit
// Holds front/back slots and the element count, decodes each operation
// into a memory access and a status, and advances the pointers on accept.
// ----------------------------------------------------------------------------
`default_nettype none

`include "double_ended_queue_core_assert.svh"

module dq_ptr #(
    parameter int DEPTH = 1024
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_fire,
    input  wire dq_pkg::t_dq_in               i_word,
    output dq_pkg::t_dq_plan                  o_plan,
    output logic      [$clog2(DEPTH)-1:0]     o_addr,
    output logic      [$clog2(DEPTH+1)-1:0]   o_count_after
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = ((AW > dq_pkg::POS_W) ? AW : dq_pkg::POS_W) + 1;
    localparam int KW = (CW > dq_pkg::POS_W) ? CW : dq_pkg::POS_W;

    logic [AW-1:0] r_front, n_front;
    logic [AW-1:0] r_back,  n_back;
    logic [CW-1:0] r_count, n_count;

    logic [AW-1:0] front_next, front_prev, back_next, back_prev;
    logic [SW-1:0] pos_sum, pos_wrap;
    logic [AW-1:0] read_addr;
    logic          full, empty, pos_bad;

    always_comb begin
        front_next = (r_front == AW'(DEPTH - 1)) ? '0 : r_front + 1'b1;
        front_prev = (r_front == '0) ? AW'(DEPTH - 1) : r_front - 1'b1;
        back_next  = (r_back == AW'(DEPTH - 1)) ? '0 : r_back + 1'b1;
        back_prev  = (r_back == '0) ? AW'(DEPTH - 1) : r_back - 1'b1;

        // front + position stays below twice the depth when in range
        pos_sum   = SW'(r_front) + SW'(i_word.position);
        pos_wrap  = (pos_sum >= SW'(DEPTH)) ? pos_sum - SW'(DEPTH) : pos_sum;
        read_addr = pos_wrap[AW-1:0];

        full    = (r_count == CW'(DEPTH));
        empty   = (r_count == '0);
        pos_bad = (KW'(i_word.position) >= KW'(r_count));
    end

    always_comb begin
        n_front = r_front;
        n_back  = r_back;
        n_count = r_count;
        o_addr  = r_back;
        o_plan  = '{status: dq_pkg::STAT_OK, take_data: 1'b0,
                    mem_wr: 1'b0, mem_rd: 1'b0};
        case (dq_pkg::t_mode'(i_word.mode))
            dq_pkg::MODE_PUSH_BACK: begin
                if (full) begin
                    o_plan.status = dq_pkg::STAT_PUSH_FULL;
                end else begin
                    o_plan.mem_wr = 1'b1;
                    o_addr        = r_back;
                    n_back        = back_next;
                    n_count       = r_count + 1'b1;
                end
            end
            dq_pkg::MODE_PUSH_FRONT: begin
                if (full) begin
                    o_plan.status = dq_pkg::STAT_PUSH_FULL;
                end else begin
                    o_plan.mem_wr = 1'b1;
                    o_addr        = front_prev;
                    n_front       = front_prev;
                    n_count       = r_count + 1'b1;
                end
            end
            dq_pkg::MODE_POP_BACK: begin
                if (empty) begin
                    o_plan.status = dq_pkg::STAT_POP_EMPTY;
                end else begin
                    o_plan.mem_rd    = 1'b1;
                    o_plan.take_data = 1'b1;
                    o_addr           = back_prev;
                    n_back           = back_prev;
                    n_count          = r_count - 1'b1;
                end
            end
            dq_pkg::MODE_POP_FRONT: begin
                if (empty) begin
                    o_plan.status = dq_pkg::STAT_POP_EMPTY;
                end else begin
                    o_plan.mem_rd    = 1'b1;
                    o_plan.take_data = 1'b1;
                    o_addr           = r_front;
                    n_front          = front_next;
                    n_count          = r_count - 1'b1;
                end
            end
            dq_pkg::MODE_READ_AT: begin
                if (pos_bad) begin
                    o_plan.status = dq_pkg::STAT_BAD_POS;
                end else begin
                    o_plan.mem_rd    = 1'b1;
                    o_plan.take_data = 1'b1;
                    o_addr           = read_addr;
                end
            end
            default: begin
                // undefined modes leave everything as is
            end
        endcase
    end

    assign o_count_after = n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_back  <= '0;
            r_count <= '0;
        end else if (i_fire) begin
            r_front <= n_front;
            r_back  <= n_back;
            r_count <= n_count;
        end
    end

    `DQ_ASSERT_IMP(a_ring_ends_meet, i_clk, i_rst_n, (r_count == '0) || full, r_front == r_back, "front and back slots differ while empty or full")
    `DQ_ASSERT_NXT(a_refused_holds, i_clk, i_rst_n, i_fire && (o_plan.status != dq_pkg::STAT_OK), (r_count == $past(r_count)) && (r_front == $past(r_front)) && (r_back == $past(r_back)), "refused operation changed queue state")
    `DQ_ASSERT_NXT(a_push_counts, i_clk, i_rst_n, i_fire && o_plan.mem_wr, r_count == $past(r_count) + 1'b1, "accepted push did not add one element")

endmodule

`default_nettype wire
